// ===== sv/b2a_pkg.sv =====
// ----------------------------------------------------------------------------
// b2a_pkg
// shared types and constants of the binary to ascii decimal converter
// ----------------------------------------------------------------------------
package b2a_pkg;

  localparam int VALUE_W    = 16;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 5;
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int CHAR_W     = 6;
  localparam int POS_W      = 3;
  localparam int NUM_CELLS  = VALUE_W;

  localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(NUM_DIGITS - 1);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic   valid;
    bcd_t   bcd;
    value_t bin;
  } stage_t;

endpackage

// ===== sv/b2a_cell.sv =====
// ----------------------------------------------------------------------------
// b2a_cell
// one shift-and-add-3 step of the conversion, registered
// ----------------------------------------------------------------------------
module b2a_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  b2a_pkg::stage_t stage_in,
  output b2a_pkg::stage_t stage_out
);
  import b2a_pkg::*;

  logic   valid_r;
  bcd_t   bcd_r;
  value_t bin_r;
  bcd_t   adj;
  bcd_t   bcd_nxt;
  value_t bin_nxt;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (stage_in.bcd[i*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
        adj[i*DIGIT_W +: DIGIT_W] = stage_in.bcd[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = stage_in.bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign bcd_nxt = {adj[BCD_W-2:0], stage_in.bin[VALUE_W-1]};
  assign bin_nxt = {stage_in.bin[VALUE_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bcd_r <= bcd_nxt;
      bin_r <= bin_nxt;
    end
  end

  assign stage_out = '{valid: valid_r, bcd: bcd_r, bin: bin_r};

endmodule

// ===== sv/b2a_serializer.sv =====
// ----------------------------------------------------------------------------
// b2a_serializer
// drops leading zeros and sends the digits out one per transfer
// ----------------------------------------------------------------------------
module b2a_serializer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  b2a_pkg::stage_t             stage_in,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [b2a_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last
);
  import b2a_pkg::*;

  logic              busy_r;
  logic [POS_W-1:0]  pos_r;
  bcd_t              bcd_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_digit_r;
  logic              out_last_r;
  logic              out_free;
  logic              emit;
  logic              finishing;
  logic [POS_W-1:0]  first;
  bcd_t              bcd_aligned;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_free;
  assign finishing = emit && (pos_r == LAST_POS);
  assign take      = stage_in.valid && (!busy_r || finishing);

  // index of the first significant digit, units always kept
  always_comb begin
    first = LAST_POS;
    for (int i = NUM_DIGITS - 2; i >= 0; i--) begin
      if (stage_in.bcd[(NUM_DIGITS-1-i)*DIGIT_W +: DIGIT_W] != '0) begin
        first = POS_W'(i);
      end
    end
  end

  assign bcd_aligned = stage_in.bcd << {first, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= emit;
      end
      if (take) begin
        busy_r <= 1'b1;
      end else if (finishing) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_digit_r <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd_r[BCD_W-1 -: DIGIT_W]};
      out_last_r  <= (pos_r == LAST_POS);
    end
    if (take) begin
      bcd_r <= bcd_aligned;
      pos_r <= first;
    end else if (emit) begin
      bcd_r <= bcd_r << DIGIT_W;
      pos_r <= pos_r + POS_W'(1);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_digit_r;
  assign out_last       = out_last_r;

endmodule

// ===== sv/binary_to_ascii_decimal_5digit_core.sv =====
// ----------------------------------------------------------------------------
// binary_to_ascii_decimal_5digit_core
// 16-bit unsigned value to ascii decimal text with leading zeros dropped
// ----------------------------------------------------------------------------
// Each accepted value runs through a row of sixteen shift-and-add-3 cells, one
// input bit per cell. From the last cell it passes the serializer's digit
// register and then its output register. The
// output stage sends one ASCII digit per transfer, most significant first, with
// out_last on the units digit; zero gives a single '0'. The output port moves
// one digit per cycle while out_stall is low, so a value with n significant
// digits holds it for n transfers. Values enter back to back while the cells
// hold earlier ones, and the whole row holds still while the last cell is full
// and the output stage is busy and not sending its last digit.
module binary_to_ascii_decimal_5digit_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [b2a_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [b2a_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last
);
  import b2a_pkg::*;

  stage_t stage [NUM_CELLS+1];
  logic   advance;
  logic   take;

  assign advance  = !stage[NUM_CELLS].valid || take;
  assign in_stall = !advance;

  assign stage[0] = '{valid: in_valid, bcd: '0, bin: in_value};

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    b2a_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .stage_in  (stage[g]),
      .stage_out (stage[g+1])
    );
  end

  b2a_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .stage_in       (stage[NUM_CELLS]),
    .take           (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

// ===== sv/b2a_checker.sv =====
// ----------------------------------------------------------------------------
// b2a_checker
// port-level checks on the digit stream of the converter
// ----------------------------------------------------------------------------
module b2a_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [b2a_pkg::CHAR_W-1:0]  out_digit_char,
  input logic                        out_last
);
  import b2a_pkg::*;

  logic             out_xfer;
  logic             start_r;
  logic [POS_W-1:0] run_cnt_r;

  assign out_xfer = out_valid && !out_stall;

  // start of a run and digits already sent in it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= 1'b1;
      run_cnt_r <= '0;
    end else if (out_xfer) begin
      start_r   <= out_last;
      run_cnt_r <= out_last ? '0 : run_cnt_r + POS_W'(1);
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit_char) && $stable(out_last))
    else $error("stalled result changed");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= ASCII_ZERO) && (out_digit_char <= ASCII_ZERO + CHAR_W'(9)))
    else $error("result is not a decimal digit");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && start_r && !out_last |-> out_digit_char != ASCII_ZERO)
    else $error("leading zero sent");

  a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (run_cnt_r < LAST_POS) || out_last)
    else $error("run longer than five digits");

endmodule

bind binary_to_ascii_decimal_5digit_core b2a_checker u_b2a_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_digit_char (out_digit_char),
  .out_last       (out_last)
);
